[rtl/core/gosd_pkg.sv]
`timescale 1ns / 1ps
package gosd_pkg;

    localparam int DW = 64;
    localparam int PW = 2 * DW;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam logic signed [DW-1:0] LIM = 64'sh1FFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPACING,
        REG_MAJOR,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_DURATION,
        REG_ENABLE
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PER,
        ST_SNAP1,
        ST_SNAP2,
        ST_BRANCH,
        ST_OMEGA,
        ST_X,
        ST_X2,
        ST_A1,
        ST_X3,
        ST_B1,
        ST_EX,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_T5,
        ST_Q0,
        ST_Q1,
        ST_WRAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        logic signed [DW-1:0] s;
        s = a + b;
        if (s > LIM)
            return LIM;
        else if (s < -LIM)
            return -LIM;
        return s;
    endfunction

    function automatic logic [DW-1:0] floor_mod(input logic neg, input logic [DW-1:0] rem,
                                                input logic [DW-1:0] den);
        return (neg && rem != '0) ? den - rem : rem;
    endfunction

endpackage

[rtl/core/gosd_cfg_if.sv]
`timescale 1ns / 1ps
interface gosd_cfg_if;
    import gosd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/gosd_req_if.sv]
`timescale 1ns / 1ps
interface gosd_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic [18:0]        frame_dt;
    modport source (output valid, output camera_x, output camera_y, output frame_dt,
                    input ready);
    modport sink (input valid, input camera_x, input camera_y, input frame_dt,
                  output ready);
endinterface

[rtl/core/gosd_rsp_if.sv]
`timescale 1ns / 1ps
interface gosd_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] offset_x;
    logic [30:0] offset_y;
    modport source (output valid, output offset_x, output offset_y, input ready);
    modport sink (input valid, input offset_x, input offset_y, output ready);
endinterface

[rtl/core/gosd_mul.sv]
`timescale 1ns / 1ps
module gosd_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [gosd_pkg::DW-1:0] a,
    input  logic [gosd_pkg::DW-1:0] b,
    output logic [gosd_pkg::PW-1:0] prod,
    output gosd_pkg::unit_stat_t    stat
);
    import gosd_pkg::*;

    logic [DW-1:0]    a_reg;
    logic [DW-1:0]    hi_reg;
    logic [DW-1:0]    lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW:0]      sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(DW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(DW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (cnt_reg != '0)
        begin
            hi_reg <= sum[DW:1];
            lo_reg <= {sum[0], lo_reg[DW-1:1]};
        end
    end

    assign prod      = {hi_reg, lo_reg};
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

[rtl/core/gosd_div.sv]
`timescale 1ns / 1ps
module gosd_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [gosd_pkg::DW-1:0] num,
    input  logic [gosd_pkg::DW-1:0] den,
    output logic [gosd_pkg::DW-1:0] quo,
    output logic [gosd_pkg::DW-1:0] rem,
    output gosd_pkg::unit_stat_t    stat
);
    import gosd_pkg::*;

    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW:0]      sh;
    logic [DW:0]      diff;
    logic             ge;

    assign sh   = {rem_reg, quo_reg[DW-1]};
    assign ge   = (sh >= {1'b0, den_reg});
    assign diff = sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(DW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DW-1:0] : sh[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

[rtl/core/grid_offset_smooth_damp_core.sv]
`timescale 1ns / 1ps
// Grid offset with critically damped smoothing. Each request carries a camera
// position and a frame time; the response is the grid offset per axis within
// one major period. All arithmetic runs on one bit-serial multiplier and one
// bit-serial divider, each working one bit a cycle over a 64-bit word. A
// request therefore takes 5 unit operations when smoothing is off or on the
// first smoothed frame, and 26 unit operations with smoothing active. One
// request is in flight at a time; a finished response waits in an output
// register, so the next request can be taken while it is pending. Configuration
// is to be written only while the block is idle; the block itself does not enforce
// this. cfg.ready is tied high, so each write is taken as soon as it is offered.
module grid_offset_smooth_damp_core #(
    parameter int FRAC_BITS  = gosd_pkg::FRAC_BITS_DEF,
    parameter int WORD_WIDTH = gosd_pkg::WORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gosd_cfg_if.sink     cfg,
    gosd_req_if.sink     req,
    gosd_rsp_if.source   rsp
);
    import gosd_pkg::*;

    localparam longint ONE_L    = longint'(1) << FRAC_BITS;
    localparam longint MSP_L    = (ONE_L + 5000) / 10000;
    localparam longint MST_L    = (ONE_L + 500) / 1000;
    localparam longint MIN_SP_L = (MSP_L < 1) ? 1 : MSP_L;
    localparam longint MIN_ST_L = (MST_L < 1) ? 1 : MST_L;
    localparam longint C1_L     = (48 * ONE_L + 50) / 100;
    localparam longint C2_L     = (235 * ONE_L + 500) / 1000;
    localparam longint THR_L    = 1000 * ONE_L;

    localparam logic signed [DW-1:0] ONE_Q     = DW'(ONE_L);
    localparam logic signed [DW-1:0] MIN_SP    = DW'(MIN_SP_L);
    localparam logic signed [DW-1:0] MIN_ST    = DW'(MIN_ST_L);
    localparam logic signed [DW-1:0] C1        = DW'(C1_L);
    localparam logic signed [DW-1:0] C2        = DW'(C2_L);
    localparam logic [PW-1:0]        THR2      = PW'(THR_L) * PW'(THR_L);
    localparam logic signed [DW-1:0] OMEGA_NUM = DW'(2) << (2 * FRAC_BITS);
    localparam logic signed [DW-1:0] EX_NUM    = DW'(1) << (2 * FRAC_BITS);
    localparam logic signed [DW-1:0] WORD_HI   = (DW'(1) << (WORD_WIDTH - 1)) - DW'(1);
    localparam logic signed [DW-1:0] WORD_LO   = -WORD_HI - DW'(1);
    localparam logic signed [DW-1:0] OUT_MAX   = DW'(32'h7FFF_FFFF);

    function automatic logic signed [WORD_WIDTH-1:0] clamp_word(
        input logic signed [DW-1:0] v);
        if (v > WORD_HI)
            return WORD_HI[WORD_WIDTH-1:0];
        else if (v < WORD_LO)
            return WORD_LO[WORD_WIDTH-1:0];
        return v[WORD_WIDTH-1:0];
    endfunction

    function automatic logic [30:0] clamp_out(input logic signed [DW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > OUT_MAX)
            return OUT_MAX[30:0];
        return v[30:0];
    endfunction

    // configuration
    logic [30:0]        spacing_reg;
    logic [15:0]        major_reg;
    logic signed [31:0] org_reg [2];
    logic [30:0]        duration_reg;
    logic               enable_reg;

    // control
    state_t state_reg, state_next;
    logic   launched_reg, launched_next;
    logic   axis_reg, axis_next;
    logic   first_reg;
    logic   rsp_valid_reg;

    // spring state
    logic signed [WORD_WIDTH-1:0] sm_reg [2];
    logic signed [WORD_WIDTH-1:0] vel_reg [2];

    // work registers
    logic signed [31:0]   cam_reg [2];
    logic [18:0]          dt_reg;
    logic signed [DW-1:0] per_reg, s_reg, omega_reg, x_reg, x2_reg, a1_reg, b1_reg;
    logic signed [DW-1:0] ex_reg, temp_reg, t_reg;
    logic signed [DW-1:0] snap_reg [2];
    logic signed [DW-1:0] chg_reg [2];
    logic signed [DW-1:0] nv_reg [2];
    logic signed [DW-1:0] ns_reg [2];
    logic [PW-1:0]        sq_reg;
    logic                 tele_reg;
    logic [30:0]          off_reg [2];

    // units
    logic                 mul_start, div_start;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        quo, rem;
    unit_stat_t           mul_stat, div_stat;

    // datapath
    logic signed [DW-1:0] sp, st, mi1, den;
    logic signed [DW-1:0] sm_cur, vel_cur, d0, delta, chg_cur;
    logic signed [DW-1:0] opa, opb, dnum, dden;
    logic                 is_mul, op_done;
    logic [DW-1:0]        mq_mag, fmod_res;
    logic signed [DW-1:0] mq;
    logic [PW-1:0]        sq_sum;
    logic signed [DW-1:0] wrap_src;

    assign sp  = ($signed(DW'(spacing_reg)) < MIN_SP) ? MIN_SP : DW'(spacing_reg);
    assign st  = ($signed(DW'(duration_reg)) < MIN_ST) ? MIN_ST : DW'(duration_reg);
    assign mi1 = (major_reg == '0) ? DW'(1) : DW'(major_reg);
    assign den = sadd(sadd(ONE_Q, x_reg), sadd(a1_reg, b1_reg));

    assign sm_cur  = DW'(sm_reg[axis_reg]);
    assign vel_cur = DW'(vel_reg[axis_reg]);
    assign d0      = snap_reg[axis_reg] - sm_cur;

    always_comb
    begin
        delta = d0;
        if ((d0 <<< 1) > per_reg)
            delta = d0 - per_reg;
        else if ((d0 <<< 1) < -per_reg)
            delta = d0 + per_reg;
    end

    assign chg_cur  = -delta;
    assign wrap_src = tele_reg ? snap_reg[axis_reg] : ns_reg[axis_reg];

    always_comb
    begin
        opa    = '0;
        opb    = '0;
        dnum   = '0;
        dden   = DW'(1);
        is_mul = 1'b1;
        case (state_reg)
            ST_PER:
            begin
                opa = sp;
                opb = mi1;
            end
            ST_X:
            begin
                opa = omega_reg;
                opb = DW'(dt_reg);
            end
            ST_X2:
            begin
                opa = x_reg;
                opb = x_reg;
            end
            ST_A1:
            begin
                opa = C1;
                opb = x2_reg;
            end
            ST_X3:
            begin
                opa = x2_reg;
                opb = x_reg;
            end
            ST_B1:
            begin
                opa = C2;
                opb = t_reg;
            end
            ST_T1:
            begin
                opa = omega_reg;
                opb = chg_cur;
            end
            ST_T2:
            begin
                opa = sadd(vel_cur, t_reg);
                opb = DW'(dt_reg);
            end
            ST_T3:
            begin
                opa = omega_reg;
                opb = temp_reg;
            end
            ST_T4:
            begin
                opa = sadd(vel_cur, -t_reg);
                opb = ex_reg;
            end
            ST_T5:
            begin
                opa = sadd(chg_reg[axis_reg], temp_reg);
                opb = ex_reg;
            end
            ST_Q0:
            begin
                opa = DW'(mag(chg_reg[0]));
                opb = DW'(mag(chg_reg[0]));
            end
            ST_Q1:
            begin
                opa = DW'(mag(chg_reg[1]));
                opb = DW'(mag(chg_reg[1]));
            end
            ST_SNAP1:
            begin
                is_mul = 1'b0;
                dnum   = DW'(cam_reg[axis_reg]) - DW'(org_reg[axis_reg]);
                dden   = sp;
            end
            ST_SNAP2:
            begin
                is_mul = 1'b0;
                dnum   = s_reg;
                dden   = per_reg;
            end
            ST_OMEGA:
            begin
                is_mul = 1'b0;
                dnum   = OMEGA_NUM;
                dden   = st;
            end
            ST_EX:
            begin
                is_mul = 1'b0;
                dnum   = EX_NUM;
                dden   = den;
            end
            ST_WRAP:
            begin
                is_mul = 1'b0;
                dnum   = wrap_src;
                dden   = per_reg;
            end
            default:
            begin
                is_mul = 1'b1;
            end
        endcase
    end

    assign mq_mag   = (|prod[PW-1:FRAC_BITS+61]) ? DW'(LIM)
                                                 : DW'(prod[FRAC_BITS+60:FRAC_BITS]);
    assign mq       = (opa[DW-1] != opb[DW-1]) ? -$signed(mq_mag) : $signed(mq_mag);
    assign fmod_res = floor_mod(dnum[DW-1], rem, dden);
    assign sq_sum   = sq_reg + prod;
    assign op_done  = launched_reg && (is_mul ? mul_stat.done : div_stat.done);

    gosd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag(opa)),
        .b     (mag(opb)),
        .prod  (prod),
        .stat  (mul_stat)
    );

    gosd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag(dnum)),
        .den   (dden),
        .quo   (quo),
        .rem   (rem),
        .stat  (div_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
            axis_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            axis_reg     <= axis_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        axis_next     = axis_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                axis_next = 1'b0;
                if (req.valid)
                    state_next = ST_PER;
            end
            ST_BRANCH:
            begin
                axis_next = 1'b0;
                if (!enable_reg || first_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_OMEGA;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                if (!launched_reg)
                begin
                    launched_next = 1'b1;
                    mul_start     = is_mul;
                    div_start     = !is_mul;
                end
                else if (op_done)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        ST_PER:   state_next = ST_SNAP1;
                        ST_SNAP1: state_next = ST_SNAP2;
                        ST_SNAP2:
                        begin
                            axis_next  = !axis_reg;
                            state_next = axis_reg ? ST_BRANCH : ST_SNAP1;
                        end
                        ST_OMEGA: state_next = ST_X;
                        ST_X:     state_next = ST_X2;
                        ST_X2:    state_next = ST_A1;
                        ST_A1:    state_next = ST_X3;
                        ST_X3:    state_next = ST_B1;
                        ST_B1:    state_next = ST_EX;
                        ST_EX:    state_next = ST_T1;
                        ST_T1:    state_next = ST_T2;
                        ST_T2:    state_next = ST_T3;
                        ST_T3:    state_next = ST_T4;
                        ST_T4:    state_next = ST_T5;
                        ST_T5:
                        begin
                            axis_next  = !axis_reg;
                            state_next = axis_reg ? ST_Q0 : ST_T1;
                        end
                        ST_Q0:    state_next = ST_Q1;
                        ST_Q1:    state_next = ST_WRAP;
                        ST_WRAP:
                        begin
                            axis_next  = !axis_reg;
                            state_next = axis_reg ? ST_DONE : ST_WRAP;
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // configuration, spring state and response handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= 31'd65536;
            major_reg     <= 16'd10;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            duration_reg  <= 31'd6554;
            enable_reg    <= 1'b0;
            first_reg     <= 1'b1;
            sm_reg[0]     <= '0;
            sm_reg[1]     <= '0;
            vel_reg[0]    <= '0;
            vel_reg[1]    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_SPACING:  spacing_reg  <= cfg.data[30:0];
                    REG_MAJOR:    major_reg    <= cfg.data[15:0];
                    REG_ORIGIN_X: org_reg[0]   <= cfg.data;
                    REG_ORIGIN_Y: org_reg[1]   <= cfg.data;
                    REG_DURATION: duration_reg <= cfg.data[30:0];
                    REG_ENABLE:   enable_reg   <= cfg.data[0];
                    default:      enable_reg   <= enable_reg;
                endcase
            end
            if (state_reg == ST_BRANCH && (!enable_reg || first_reg))
            begin
                sm_reg[0]  <= clamp_word(snap_reg[0]);
                sm_reg[1]  <= clamp_word(snap_reg[1]);
                vel_reg[0] <= '0;
                vel_reg[1] <= '0;
                first_reg  <= !enable_reg;
            end
            if (state_reg == ST_WRAP && op_done)
            begin
                sm_reg[axis_reg]  <= clamp_word(DW'(fmod_res));
                vel_reg[axis_reg] <= tele_reg ? '0 : clamp_word(nv_reg[axis_reg]);
            end
            if (state_reg == ST_DONE && !rsp_valid_reg)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            cam_reg[0] <= req.camera_x;
            cam_reg[1] <= req.camera_y;
            dt_reg     <= req.frame_dt;
        end
        if (op_done)
        begin
            case (state_reg)
                ST_PER:   per_reg <= prod[DW-1:0];
                ST_SNAP1: s_reg <= dnum - $signed(fmod_res);
                ST_SNAP2: snap_reg[axis_reg] <= fmod_res;
                ST_OMEGA: omega_reg <= quo;
                ST_X:     x_reg <= mq;
                ST_X2:    x2_reg <= mq;
                ST_A1:    a1_reg <= mq;
                ST_X3:    t_reg <= mq;
                ST_B1:    b1_reg <= mq;
                ST_EX:    ex_reg <= quo;
                ST_T1:
                begin
                    t_reg             <= mq;
                    chg_reg[axis_reg] <= chg_cur;
                end
                ST_T2:    temp_reg <= mq;
                ST_T3:    t_reg <= mq;
                ST_T4:    nv_reg[axis_reg] <= mq;
                ST_T5:    ns_reg[axis_reg] <= sadd(sm_cur - chg_reg[axis_reg], mq);
                ST_Q0:    sq_reg <= prod;
                ST_Q1:    tele_reg <= (sq_sum > THR2);
                default:  sq_reg <= sq_reg;
            endcase
        end
        if (state_reg == ST_DONE && !rsp_valid_reg)
        begin
            off_reg[0] <= enable_reg ? clamp_out(DW'(sm_reg[0])) : clamp_out(snap_reg[0]);
            off_reg[1] <= enable_reg ? clamp_out(DW'(sm_reg[1])) : clamp_out(snap_reg[1]);
        end
    end

    assign cfg.ready    = 1'b1;
    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.offset_x = off_reg[0];
    assign rsp.offset_y = off_reg[1];

endmodule
